// File: sv/tdts_pkg.sv
// shared types and constants for the tick driven task scheduler
package tdts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam logic [15:0] CNT_LIMIT = 16'hFFFF;
    localparam int RELOAD_BASE = 8;
    localparam logic [7:0] PRIO_LIMIT = 8'd5;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    typedef enum logic [0:0] {
        CFG_ENABLE = 1'b0,
        CFG_POLICY = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  task_index;
        logic [15:0] counter_value;
        logic [7:0]  priority_value;
        logic        running;
        logic        present;
    } t_item;

    typedef struct packed {
        logic       switched;
        logic [2:0] next_task;
        logic       no_candidate;
        logic [2:0] current_task;
    } t_result;

endpackage

// File: sv/tick_driven_task_scheduler_top.sv
// task table, tick sequencer and shared scan comparator of the task scheduler
//
// input words arrive on i_item and are taken when start is high and busy is low.
// a write word loads one table entry; a tick word charges the current task and
// may pick a new one. every accepted word gives exactly one result word on
// o_result, marked by o_done for a single cycle; the receiver cannot stall it.
// write words and ticks while disabled: result one cycle after accept, busy
// stays low, so they can be sent back to back.
// tick without a scan: S_UPD then S_RESULT, which registers the result and o_done.
// tick with a scan: S_UPD, S_SCAN, S_DRAIN, then S_RESULT; the scan reads one
// table entry per cycle through the counter/priority memory read port and
// feeds a single shared comparator, from the top slot down to slot 1.
// busy stays high for the whole tick.
// configuration words (enable, policy) use their own valid/ready channel,
// always ready; write them only while the block is idle.
// synchronous active-low reset clears the table flags, the current task,
// enable and policy; counters of entries never written read as zero.
module tick_driven_task_scheduler_top import tdts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_item    i_item,
    output logic     o_done,
    output t_result  o_result,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_reg i_cfg_index,
    input  logic     i_cfg_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPD    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic r_enable, r_policy;
    logic [IDX_W-1:0] r_cur;
    logic [TASK_SLOTS-1:0] r_present, r_running, r_written;

    logic [15:0] mem_cnt [TASK_SLOTS];
    logic [7:0]  mem_pri [TASK_SLOTS];
    logic [15:0] r_rd_cnt;
    logic [7:0]  r_rd_pri;

    logic [IDX_W-1:0] r_scan_idx, r_cmp_idx, r_pick;
    logic             r_cmp_vld, r_did_scan;
    logic [15:0]      r_best_cnt;
    logic [7:0]       r_best_pri;

    logic             accept, in_range, wr_item, tick_go;
    logic [IDX_W-1:0] w_idx, rd_addr, mem_waddr;
    logic             mem_we;
    logic [15:0]      mem_wcnt, cur_cnt, dec_cnt, upd_cnt;
    logic             need_scan;
    logic             elig, win;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign accept   = start && !busy;
    assign in_range = 32'(i_item.task_index) < TASK_SLOTS;
    assign w_idx    = IDX_W'(i_item.task_index);
    assign wr_item  = accept && (i_item.kind == KIND_WRITE) && in_range;
    assign tick_go  = accept && (i_item.kind == KIND_TICK) && r_enable;

    // charge the current task, saturate at zero, reload under priority policy
    assign cur_cnt   = r_written[r_cur] ? r_rd_cnt : 16'd0;
    assign dec_cnt   = (cur_cnt != 16'd0) ? cur_cnt - 16'd1 : 16'd0;
    assign upd_cnt   = (r_policy && dec_cnt == 16'd0 && r_cur != '0)
                       ? 16'(RELOAD_BASE) - 16'(r_cur) : dec_cnt;
    assign need_scan = r_policy || (dec_cnt == 16'd0);

    assign mem_we    = wr_item || (r_state == S_UPD);
    assign mem_waddr = (r_state == S_UPD) ? r_cur : w_idx;
    assign mem_wcnt  = (r_state == S_UPD) ? upd_cnt : i_item.counter_value;
    assign rd_addr   = (r_state == S_SCAN) ? r_scan_idx : r_cur;

    // shared comparator: candidate entry against best so far
    always_comb begin
        elig = r_cmp_vld && r_present[r_cmp_idx] && r_running[r_cmp_idx];
        if (r_policy) begin
            win = elig && ((r_rd_pri < r_best_pri) ||
                           (r_rd_pri == r_best_pri && r_rd_cnt < r_best_cnt));
        end else begin
            win = elig && (r_rd_cnt != 16'd0) && (r_rd_cnt < r_best_cnt);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_go) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = need_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                if (r_scan_idx == IDX_W'(1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // counter and priority storage, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_cnt[mem_waddr] <= mem_wcnt;
        end
        if (wr_item) begin
            mem_pri[w_idx] <= i_item.priority_value;
        end
        r_rd_cnt <= mem_cnt[rd_addr];
        r_rd_pri <= mem_pri[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_enable   <= 1'b0;
            r_policy   <= 1'b0;
            r_cur      <= '0;
            r_present  <= '0;
            r_running  <= '0;
            r_written  <= '0;
            r_cmp_vld  <= 1'b0;
            r_did_scan <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= (accept && !tick_go) || (r_state == S_RESULT);

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data;
                    CFG_POLICY: r_policy <= i_cfg_data;
                    default: ;
                endcase
            end

            if (wr_item) begin
                r_present[w_idx] <= i_item.present;
                r_running[w_idx] <= i_item.running;
                r_written[w_idx] <= 1'b1;
            end

            if (r_state == S_UPD) begin
                r_written[r_cur] <= 1'b1;
            end

            // write words and disabled ticks answer at once
            if (accept && !tick_go) begin
                o_result.switched     <= 1'b0;
                o_result.next_task    <= 3'd0;
                o_result.no_candidate <= 1'b0;
                o_result.current_task <= 3'(r_cur);
            end

            case (r_state)
                S_UPD: begin
                    r_did_scan <= need_scan;
                    r_scan_idx <= IDX_W'(TASK_SLOTS - 1);
                    r_cmp_vld  <= 1'b0;
                    r_best_cnt <= CNT_LIMIT;
                    r_best_pri <= PRIO_LIMIT;
                    r_pick     <= '0;
                end
                S_SCAN, S_DRAIN: begin
                    if (win) begin
                        r_best_cnt <= r_rd_cnt;
                        r_best_pri <= r_rd_pri;
                        r_pick     <= r_cmp_idx;
                    end
                    r_cmp_idx  <= r_scan_idx;
                    r_cmp_vld  <= (r_state == S_SCAN);
                    r_scan_idx <= r_scan_idx - IDX_W'(1);
                end
                S_RESULT: begin
                    if (r_did_scan && r_pick != '0) begin
                        o_result.switched     <= (r_pick != r_cur);
                        o_result.next_task    <= 3'(r_pick);
                        o_result.no_candidate <= 1'b0;
                        o_result.current_task <= 3'(r_pick);
                        r_cur                 <= r_pick;
                    end else begin
                        o_result.switched     <= 1'b0;
                        o_result.next_task    <= 3'd0;
                        o_result.no_candidate <= r_did_scan;
                        o_result.current_task <= 3'(r_cur);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: sv/tdts_checker.sv
// port-level checks for the task scheduler, bound to the top level
module tdts_checker import tdts_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_item    i_item,
    input logic     o_done,
    input t_result  o_result,
    input logic     i_cfg_valid,
    input logic     o_cfg_ready,
    input t_cfg_reg i_cfg_index,
    input logic     i_cfg_data
);

    // reset leaves the block idle with no result word
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done)
        else $error("block not idle after reset");

    // a result word only appears once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result word while busy");

    // a tick finishing always delivers its word
    a_tick_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("tick ended without a result word");

    // a switch lands on the chosen task, never on slot zero
    a_switch_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.switched |->
            o_result.current_task == o_result.next_task &&
            o_result.next_task != 3'd0 && !o_result.no_candidate)
        else $error("switch target mismatch");

endmodule

bind tick_driven_task_scheduler_top tdts_checker u_tdts_checker (.*);
